[rtl/core/scalar_to_rgb_colormap_core_macros.svh]
// Assertion macros shared by the colormap RTL.
`ifndef SCALAR_TO_RGB_COLORMAP_CORE_MACROS_SVH
`define SCALAR_TO_RGB_COLORMAP_CORE_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define S2RGB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define S2RGB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/s2rgb_pkg.sv]
// Shared constants, types and the palette table of the scalar colormap.
`default_nettype none

package s2rgb_pkg;

  // Sample and range register width (signed Q16.16).
  localparam int DATA_W          = 32;
  // Offset and span are formed one bit wider than a sample.
  localparam int OFF_W           = DATA_W + 1;
  // Fraction bits of the normalized position t.
  localparam int FRAC_BITS       = 16;
  // Number of palette positions the position is spread across.
  localparam int PALETTE_ENTRIES = 11;
  // Position t runs from 0 to 1.0 inclusive.
  localparam int T_W             = FRAC_BITS + 1;
  localparam logic [T_W-1:0] ONE_T = T_W'(1) << FRAC_BITS;
  // Span used for an empty or inverted range: 1.0 in Q16.16.
  localparam logic [DATA_W-1:0] ONE_Q16 = DATA_W'(32'h0001_0000);

  // Palette index and position widths.
  localparam int IDX_W   = $clog2(PALETTE_ENTRIES);
  localparam int POS_W   = T_W + $clog2(PALETTE_ENTRIES);
  localparam int IPART_W = POS_W - FRAC_BITS;

  // Palette colors, exact integers in units of 1/10000.
  localparam int COL_W      = 14;
  localparam int TABLE_LEN  = 11;
  localparam int TBL_IDX_W  = $clog2(TABLE_LEN);
  localparam int IDX_WIDE_W = (IDX_W > TBL_IDX_W) ? IDX_W : TBL_IDX_W;

  // Blend datapath widths.
  localparam int PROD_W = COL_W + T_W;
  localparam int BL_W   = PROD_W + 1;
  localparam int SC_W   = BL_W + 8;
  // A blended channel times 255 over 2^FRAC_BITS stays below 255 * 10000.
  localparam int Q1_W   = 22;

  // Division by 10000 as a multiplication by a rounded-up reciprocal.
  localparam int RECIP_W  = 23;
  localparam int RECIP_SH = 36;
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(6871948);
  localparam int RPROD_W  = Q1_W + RECIP_W;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_RANGE_LOW  = 2'd0,
    REG_RANGE_HIGH = 2'd1,
    REG_MAP_SELECT = 2'd2
  } cfg_reg_t;

  // Item entering the divider: offset from the low end and the span.
  typedef struct packed {
    logic [OFF_W-1:0]  off;
    logic [DATA_W-1:0] span;
    logic              last;
  } div_in_t;

  // Item leaving the divider: normalized, clamped position.
  typedef struct packed {
    logic [T_W-1:0] t;
    logic           last;
  } div_out_t;

  // Diverging red-blue palette, one row per entry: red, green, blue.
  localparam logic [COL_W-1:0] PAL_TABLE [TABLE_LEN][3] = '{
    '{14'd196,  14'd1882, 14'd3804},
    '{14'd1294, 14'd4000, 14'd6745},
    '{14'd2627, 14'd5765, 14'd7647},
    '{14'd5725, 14'd7725, 14'd8706},
    '{14'd8196, 14'd8980, 14'd9412},
    '{14'd9686, 14'd9686, 14'd9686},
    '{14'd9922, 14'd8588, 14'd7804},
    '{14'd9882, 14'd6824, 14'd5529},
    '{14'd9569, 14'd4275, 14'd2627},
    '{14'd8392, 14'd1529, 14'd1569},
    '{14'd6471, 14'd0,    14'd1490}
  };

  // Palette lookup; indexes past the table repeat its last color.
  function automatic logic [COL_W-1:0] pal_color(input logic [IDX_W-1:0] idx,
                                                 input logic [1:0]       ch);
    logic [IDX_WIDE_W-1:0] wide;
    wide = IDX_WIDE_W'(idx);
    if (wide >= IDX_WIDE_W'(TABLE_LEN)) begin
      wide = IDX_WIDE_W'(TABLE_LEN - 1);
    end
    return PAL_TABLE[wide[TBL_IDX_W-1:0]][ch];
  endfunction

endpackage

`default_nettype wire

[rtl/core/scalar_to_rgb_colormap_core.sv]
// Top level of the scalar-to-RGB colormap: range setup, divider and color blend.
`default_nettype none
`include "scalar_to_rgb_colormap_core_macros.svh"

// Maps one signed Q16.16 sample per item to an RGB byte triple. The sample is
// normalized against range_low/range_high (an empty or inverted range counts
// as a span of 1.0), clamped to [0,1] and either copied to all three channels
// (map_select 0) or blended between two adjacent entries of an 11-color
// red-blue palette (map_select 1). The block takes one item per clock while
// the output is not stalled. An item crosses 22 register stages: one for
// offset and span, loaded at the accepting edge, FRAC_BITS (16) in the
// one-bit-per-stage divider, and five for palette blend, scaling and output.
// Each stage moves whenever a later stage has room, so gaps on the input are
// squeezed out while the output is stalled. Configuration writes take effect
// at once and are meant for an idle pipeline.
module scalar_to_rgb_colormap_core
  import s2rgb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Input stream.
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [DATA_W-1:0] in_tdata,   // [31:0] sample
  input  wire logic              in_tlast,   // last_in
  // Result stream.
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [23:0]            out_tdata,  // [7:0] red, [15:8] green, [23:16] blue
  output logic                   out_tlast,  // last_out
  // Configuration write port.
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [DATA_W-1:0] cfg_data
);

  localparam int NB = 5;

  // Configuration registers.
  logic [DATA_W-1:0] range_low_r;
  logic [DATA_W-1:0] range_high_r;
  logic              map_select_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= '0;
      range_high_r <= ONE_Q16;
      map_select_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_RANGE_LOW:  range_low_r  <= cfg_data;
        REG_RANGE_HIGH: range_high_r <= cfg_data;
        REG_MAP_SELECT: map_select_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Front stage: offset and span.
  logic              s1_v_r;
  logic              s1_en;
  div_in_t           s1_r;
  div_in_t           s1_nxt;
  logic              div_in_ready;
  logic [OFF_W-1:0]  lo_ext;
  logic [OFF_W-1:0]  hi_ext;
  logic [OFF_W-1:0]  span_ext;

  assign lo_ext   = {range_low_r[DATA_W-1], range_low_r};
  assign hi_ext   = {range_high_r[DATA_W-1], range_high_r};
  assign span_ext = hi_ext - lo_ext;

  always_comb begin
    s1_nxt.off  = {in_tdata[DATA_W-1], in_tdata} - lo_ext;
    s1_nxt.last = in_tlast;
    if (span_ext[OFF_W-1] || (span_ext == '0)) begin
      s1_nxt.span = ONE_Q16;
    end else begin
      s1_nxt.span = span_ext[DATA_W-1:0];
    end
  end

  assign s1_en     = div_in_ready || !s1_v_r;
  assign in_tready = s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_en) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_r <= s1_nxt;
    end
  end

  // Normalization divider.
  logic     div_out_valid;
  div_out_t div_out;
  logic     bv_r [NB];
  logic     en_b [NB];

  s2rgb_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_v_r),
    .in_ready  (div_in_ready),
    .in_data   (s1_r),
    .out_valid (div_out_valid),
    .out_ready (en_b[0]),
    .out_data  (div_out)
  );

  // Back-end stage enables: move when empty or a later stage has room.
  always_comb begin
    logic all_v;
    for (int k = 0; k < NB; k++) begin
      all_v = 1'b1;
      for (int j = k; j < NB; j++) begin
        all_v = all_v & bv_r[j];
      end
      en_b[k] = out_tready || !all_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NB; k++) begin
        bv_r[k] <= 1'b0;
      end
    end else begin
      for (int k = 0; k < NB; k++) begin
        if (en_b[k]) begin
          bv_r[k] <= (k == 0) ? div_out_valid : bv_r[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // Stage m1: palette position, neighbor index and gray level.
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [IDX_W-1:0]     nidx_r, nidx_nxt;
  logic [FRAC_BITS-1:0] frac_r, frac_nxt;
  logic [7:0]           gray1_r, gray1_nxt;
  logic                 last1_r;
  logic [POS_W-1:0]     pos;
  logic [IPART_W-1:0]   ipart;
  logic [T_W+7:0]       gprod;
  logic [8:0]           g9;

  assign pos   = POS_W'(div_out.t) * POS_W'(PALETTE_ENTRIES - 1);
  assign ipart = pos[POS_W-1:FRAC_BITS];
  assign gprod = (T_W + 8)'(div_out.t) * (T_W + 8)'(255);
  assign g9    = gprod[FRAC_BITS +: 9];

  always_comb begin
    if (ipart >= IPART_W'(PALETTE_ENTRIES - 1)) begin
      idx_nxt  = IDX_W'(PALETTE_ENTRIES - 1);
      frac_nxt = '0;
      nidx_nxt = IDX_W'(PALETTE_ENTRIES - 1);
    end else begin
      idx_nxt  = ipart[IDX_W-1:0];
      frac_nxt = pos[FRAC_BITS-1:0];
      nidx_nxt = ipart[IDX_W-1:0] + IDX_W'(1);
    end
    gray1_nxt = (g9 > 9'd255) ? 8'd255 : g9[7:0];
  end

  always_ff @(posedge clk) begin
    if (en_b[0]) begin
      idx_r   <= idx_nxt;
      nidx_r  <= nidx_nxt;
      frac_r  <= frac_nxt;
      gray1_r <= gray1_nxt;
      last1_r <= div_out.last;
    end
  end

  // Stage m2: weighted palette colors.
  logic [PROD_W-1:0] p0_r [3];
  logic [PROD_W-1:0] p1_r [3];
  logic [PROD_W-1:0] p0_nxt [3];
  logic [PROD_W-1:0] p1_nxt [3];
  logic [7:0]        gray2_r;
  logic              last2_r;
  logic [T_W-1:0]    wfar;

  assign wfar = ONE_T - T_W'(frac_r);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p0_nxt[k] = PROD_W'(pal_color(idx_r, 2'(k))) * PROD_W'(wfar);
      p1_nxt[k] = PROD_W'(pal_color(nidx_r, 2'(k))) * PROD_W'(frac_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en_b[1]) begin
      for (int k = 0; k < 3; k++) begin
        p0_r[k] <= p0_nxt[k];
        p1_r[k] <= p1_nxt[k];
      end
      gray2_r <= gray1_r;
      last2_r <= last1_r;
    end
  end

  // Stage m3: blend, scale by 255 and drop the fraction bits.
  logic [Q1_W-1:0] q1_r [3];
  logic [Q1_W-1:0] q1_nxt [3];
  logic [7:0]      gray3_r;
  logic            last3_r;

  always_comb begin
    logic [SC_W-1:0] blend;
    logic [SC_W-1:0] scaled;
    for (int k = 0; k < 3; k++) begin
      blend     = SC_W'(p0_r[k]) + SC_W'(p1_r[k]);
      scaled    = (blend << 8) - blend;
      q1_nxt[k] = scaled[FRAC_BITS +: Q1_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en_b[2]) begin
      for (int k = 0; k < 3; k++) begin
        q1_r[k] <= q1_nxt[k];
      end
      gray3_r <= gray2_r;
      last3_r <= last2_r;
    end
  end

  // Stage m4: divide by 10000 through the reciprocal product.
  logic [RPROD_W-1:0] rp_r [3];
  logic [7:0]         gray4_r;
  logic               last4_r;

  always_ff @(posedge clk) begin
    if (en_b[3]) begin
      for (int k = 0; k < 3; k++) begin
        rp_r[k] <= RPROD_W'(q1_r[k]) * RPROD_W'(RECIP_M);
      end
      gray4_r <= gray3_r;
      last4_r <= last3_r;
    end
  end

  // Output stage: clamp to a byte and pick grayscale or palette color.
  logic [7:0] chan_nxt [3];
  logic [7:0] chan_r   [3];
  logic       last_o_r;

  always_comb begin
    logic [8:0] v9;
    for (int k = 0; k < 3; k++) begin
      v9 = rp_r[k][RECIP_SH +: 9];
      if (!map_select_r) begin
        chan_nxt[k] = gray4_r;
      end else if (v9 > 9'd255) begin
        chan_nxt[k] = 8'd255;
      end else begin
        chan_nxt[k] = v9[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_b[4]) begin
      for (int k = 0; k < 3; k++) begin
        chan_r[k] <= chan_nxt[k];
      end
      last_o_r <= last4_r;
    end
  end

  assign out_tvalid = bv_r[NB-1];
  assign out_tdata  = {chan_r[2], chan_r[1], chan_r[0]};
  assign out_tlast  = last_o_r;

  `S2RGB_ASSERT_NOW(a_gray_equal, out_tvalid && !map_select_r, (chan_r[0] == chan_r[1]) && (chan_r[1] == chan_r[2]), "gray item with unequal channels")
  `S2RGB_ASSERT_NOW(a_no_false_stall, out_tready, in_tready, "input stalled without output back pressure")
  `S2RGB_ASSERT_NEXT(a_cfg_low_write, cfg_we && (cfg_index == REG_RANGE_LOW), range_low_r == $past(cfg_data), "range_low write lost")

endmodule

`default_nettype wire

[rtl/core/s2rgb_div.sv]
// Pipelined restoring divider that turns offset and span into position t.
`default_nettype none
`include "scalar_to_rgb_colormap_core_macros.svh"

module s2rgb_div
  import s2rgb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire div_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output div_out_t      out_data
);

  localparam int NS = FRAC_BITS;

  // One quotient bit per stage.
  logic              dv_r    [NS];
  logic [DATA_W-1:0] rem_r   [NS];
  logic [DATA_W-1:0] den_r   [NS];
  logic [NS-1:0]     quo_r   [NS];
  logic              lo_r    [NS];
  logic              hi_r    [NS];
  logic              last_r  [NS];

  logic [DATA_W-1:0] rem_nxt [NS];
  logic [NS-1:0]     quo_nxt [NS];
  logic              en      [NS];

  logic              sat_lo;
  logic              sat_hi;

  // Out-of-range offsets bypass the quotient.
  assign sat_lo = in_data.off[OFF_W-1] || (in_data.off == '0);
  assign sat_hi = !in_data.off[OFF_W-1] && (in_data.off[DATA_W-1:0] >= in_data.span);

  // A stage moves when it is empty or some stage after it has room.
  always_comb begin
    logic all_v;
    for (int k = 0; k < NS; k++) begin
      all_v = 1'b1;
      for (int j = k; j < NS; j++) begin
        all_v = all_v & dv_r[j];
      end
      en[k] = out_ready || !all_v;
    end
  end

  assign in_ready = en[0];

  // Shift-compare-subtract step of every stage.
  always_comb begin
    logic [DATA_W-1:0] src_rem;
    logic [DATA_W-1:0] src_den;
    logic [NS-1:0]     src_quo;
    logic [DATA_W:0]   r2;
    logic              ge;
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        src_rem = in_data.off[DATA_W-1:0];
        src_den = in_data.span;
        src_quo = '0;
      end else begin
        src_rem = rem_r[k-1];
        src_den = den_r[k-1];
        src_quo = quo_r[k-1];
      end
      r2 = {src_rem, 1'b0};
      ge = (r2 >= {1'b0, src_den});
      if (ge) begin
        rem_nxt[k] = DATA_W'(r2 - {1'b0, src_den});
      end else begin
        rem_nxt[k] = DATA_W'(r2);
      end
      quo_nxt[k] = {src_quo[NS-2:0], ge};
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) begin
        dv_r[k] <= 1'b0;
      end
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          dv_r[k] <= (k == 0) ? in_valid : dv_r[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
        if (k == 0) begin
          den_r[k]  <= in_data.span;
          lo_r[k]   <= sat_lo;
          hi_r[k]   <= sat_hi;
          last_r[k] <= in_data.last;
        end else begin
          den_r[k]  <= den_r[k-1];
          lo_r[k]   <= lo_r[k-1];
          hi_r[k]   <= hi_r[k-1];
          last_r[k] <= last_r[k-1];
        end
      end
    end
  end

  // Clamp to zero below the range and to one at or above its top.
  always_comb begin
    out_valid     = dv_r[NS-1];
    out_data.last = last_r[NS-1];
    if (lo_r[NS-1]) begin
      out_data.t = '0;
    end else if (hi_r[NS-1]) begin
      out_data.t = ONE_T;
    end else begin
      out_data.t = T_W'(quo_r[NS-1]);
    end
  end

  `S2RGB_ASSERT_NOW(a_rem_below_den, dv_r[NS-1] && !lo_r[NS-1] && !hi_r[NS-1], rem_r[NS-1] < den_r[NS-1], "divider remainder not below span")
  `S2RGB_ASSERT_NOW(a_t_max, out_valid, out_data.t <= ONE_T, "position above one")
  `S2RGB_ASSERT_NOW(a_no_false_stall, out_ready, in_ready, "divider stalls without back pressure")

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the colormap core: directed table, then random phases.
module tb_top
  import s2rgb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Register index past the end of the register list; writes to it are ignored.
  localparam logic [1:0] CFG_NO_REG = 2'd3;
  localparam int TOP_ENTRY = PALETTE_ENTRIES - 1;
  localparam longint unsigned POS_ONE = 64'd1 << FRAC_BITS;
  localparam longint unsigned POS_MASK = POS_ONE - 1;
  localparam longint unsigned LEVEL_DIV = 64'd10000 << FRAC_BITS;
  localparam longint EMPTY_SPAN = 65536;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES = 30;
  localparam int DIR_ROWS = 21;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 130;
  localparam int MAX_REPORTS = 200;

  // One mapped color as it leaves the block.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } rgb_item_t;

  // One row of the directed table: range setup, sample, and an optional known color.
  typedef struct packed {
    logic [31:0] low;
    logic [31:0] high;
    logic        sel;
    logic [31:0] smp;
    logic        lst;
    logic        known;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata = '0;
  logic              in_tlast = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [23:0]       out_tdata;
  logic              out_tlast;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = 2'd0;
  logic [DATA_W-1:0] cfg_data = '0;

  // Register shadow used by the color predictor.
  logic [31:0] cur_low = 32'h0000_0000;
  logic [31:0] cur_high = 32'h0001_0000;
  logic        cur_map = 1'b1;

  rgb_item_t color_q [$];
  rgb_item_t want;
  stim_row_t dir_rows [DIR_ROWS];
  int        err_cnt = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  logic      hold_arm = 1'b0;
  logic      hold_taken = 1'b0;
  int        hold_left = 0;

  scalar_to_rgb_colormap_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Red-blue palette levels in units of 1/10000, packed red, green, blue.
  function automatic logic [41:0] palette_entry(input longint unsigned idx);
    case (idx)
      0:       return {14'd196,  14'd1882, 14'd3804};
      1:       return {14'd1294, 14'd4000, 14'd6745};
      2:       return {14'd2627, 14'd5765, 14'd7647};
      3:       return {14'd5725, 14'd7725, 14'd8706};
      4:       return {14'd8196, 14'd8980, 14'd9412};
      5:       return {14'd9686, 14'd9686, 14'd9686};
      6:       return {14'd9922, 14'd8588, 14'd7804};
      7:       return {14'd9882, 14'd6824, 14'd5529};
      8:       return {14'd9569, 14'd4275, 14'd2627};
      9:       return {14'd8392, 14'd1529, 14'd1569};
      default: return {14'd6471, 14'd0,    14'd1490};
    endcase
  endfunction

  // Normalizes one sample against the current range and maps it to a color.
  function automatic rgb_item_t predict_color(input logic [31:0] smp, input logic lst);
    longint x;
    longint lo;
    longint span;
    longint off;
    longint unsigned t;
    longint unsigned pos;
    longint unsigned idx;
    longint unsigned frac;
    longint unsigned nxt;
    longint unsigned lvl_a;
    longint unsigned lvl_b;
    longint unsigned mix;
    logic [41:0] col_a;
    logic [41:0] col_b;
    logic [7:0] chan [3];
    rgb_item_t res;
    x = longint'(signed'(smp));
    lo = longint'(signed'(cur_low));
    span = longint'(signed'(cur_high)) - lo;
    off = x - lo;
    // An empty or inverted range counts as a span of 1.0.
    if (span <= 0) begin
      span = EMPTY_SPAN;
    end
    if (off <= 0) begin
      t = 0;
    end else if (off >= span) begin
      t = POS_ONE;
    end else begin
      t = ($unsigned(off) << FRAC_BITS) / $unsigned(span);
    end
    if (cur_map == 1'b0) begin
      mix = (t * 255) >> FRAC_BITS;
      if (mix > 255) begin
        mix = 255;
      end
      for (int k = 0; k < 3; k++) begin
        chan[k] = mix[7:0];
      end
    end else begin
      pos = t * TOP_ENTRY;
      idx = pos >> FRAC_BITS;
      frac = pos & POS_MASK;
      // At the top of the palette the last entry is used without blending.
      if (idx >= TOP_ENTRY) begin
        idx = TOP_ENTRY;
        frac = 0;
      end
      nxt = (idx + 1 > TOP_ENTRY) ? TOP_ENTRY : idx + 1;
      col_a = palette_entry(idx);
      col_b = palette_entry(nxt);
      for (int k = 0; k < 3; k++) begin
        lvl_a = (col_a >> (14 * (2 - k))) & 42'h3FFF;
        lvl_b = (col_b >> (14 * (2 - k))) & 42'h3FFF;
        mix = ((lvl_a * (POS_ONE - frac) + lvl_b * frac) * 255) / LEVEL_DIV;
        if (mix > 255) begin
          mix = 255;
        end
        chan[k] = mix[7:0];
      end
    end
    res.red = chan[0];
    res.green = chan[1];
    res.blue = chan[2];
    res.last = lst;
    return res;
  endfunction

  // Drops valid and waits until every expected color has come out.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (color_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Writes all registers on an idle block, plus one write to an unused index.
  task automatic load_range(input logic [31:0] lo, input logic [31:0] hi, input logic sel);
    logic [31:0] sel_word;
    wait_drained();
    repeat (2) @(posedge clk);
    sel_word = $urandom();
    sel_word[0] = sel;
    cfg_we <= 1'b1;
    cfg_index <= REG_RANGE_LOW;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= REG_RANGE_HIGH;
    cfg_data <= hi;
    @(posedge clk);
    cfg_index <= REG_MAP_SELECT;
    cfg_data <= sel_word;
    @(posedge clk);
    cfg_index <= CFG_NO_REG;
    cfg_data <= $urandom();
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_low = lo;
    cur_high = hi;
    cur_map = sel;
  endtask

  // Offers one sample, with random idle cycles ahead of it, and records its color.
  task automatic push_sample(input logic [31:0] smp, input logic lst, input rgb_item_t exp_col);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= smp;
    in_tlast <= lst;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    color_q.insert(color_q.size(), exp_col);
  endtask

  // Result side: random stalls, and one long hold-off when the sender arms it.
  always @(posedge clk) begin
    if (hold_arm && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each accepted color item with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (color_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) begin
          $display("%0t: unexpected color item rgb %h last %b", $time, out_tdata, out_tlast);
        end
      end else begin
        want = color_q.pop_front();
        if (out_tdata[7:0] !== want.red || out_tdata[15:8] !== want.green ||
            out_tdata[23:16] !== want.blue || out_tlast !== want.last) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $display("%0t: expected rgb %0d %0d %0d last %b, got %0d %0d %0d last %b",
                     $time, want.red, want.green, want.blue, want.last,
                     out_tdata[7:0], out_tdata[15:8], out_tdata[23:16], out_tlast);
          end
        end
      end
    end
  end

  // Stimulus: reset, directed table, random phases, then the final verdict.
  initial begin : stimulus
    int phase;
    int n;
    int pick;
    logic sel;
    logic lst_bit;
    longint lo_v;
    longint hi_v;
    longint eff;
    longint val;
    logic [31:0] lo_w;
    logic [31:0] hi_w;
    logic [31:0] smp;
    rgb_item_t exp_col;

    // Low, high, select, sample, last, known, red, green, blue.
    dir_rows = '{
      // Reset range, diverging palette: bottom, top and the middle entry.
      '{32'h0000_0000, 32'h0001_0000, 1'b1, 32'h0000_0000, 1'b0, 1'b1, 8'd4,   8'd47,  8'd97},
      '{32'h0000_0000, 32'h0001_0000, 1'b1, 32'h0001_0000, 1'b0, 1'b1, 8'd165, 8'd0,   8'd37},
      '{32'h0000_0000, 32'h0001_0000, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b1, 8'd165, 8'd0,   8'd37},
      '{32'h0000_0000, 32'h0001_0000, 1'b1, 32'h8000_0000, 1'b0, 1'b1, 8'd4,   8'd47,  8'd97},
      '{32'h0000_0000, 32'h0001_0000, 1'b1, 32'h0000_8000, 1'b0, 1'b1, 8'd246, 8'd246, 8'd246},
      '{32'h0000_0000, 32'h0001_0000, 1'b1, 32'h0000_FFFF, 1'b1, 1'b0, 8'd0,   8'd0,   8'd0},
      '{32'h0000_0000, 32'h0001_0000, 1'b1, 32'h0000_1999, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
      // Grayscale over the unit range.
      '{32'h0000_0000, 32'h0001_0000, 1'b0, 32'h0000_0000, 1'b0, 1'b1, 8'd0,   8'd0,   8'd0},
      '{32'h0000_0000, 32'h0001_0000, 1'b0, 32'h0001_0000, 1'b0, 1'b1, 8'd255, 8'd255, 8'd255},
      '{32'h0000_0000, 32'h0001_0000, 1'b0, 32'h0000_8000, 1'b0, 1'b1, 8'd127, 8'd127, 8'd127},
      '{32'h0000_0000, 32'h0001_0000, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1, 8'd0,   8'd0,   8'd0},
      '{32'h0000_0000, 32'h0001_0000, 1'b0, 32'h7FFF_FFFF, 1'b1, 1'b1, 8'd255, 8'd255, 8'd255},
      // Inverted range at the extremes: span falls back to 1.0, samples at and below the low end.
      '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h7FFF_FFFF, 1'b0, 1'b1, 8'd0,   8'd0,   8'd0},
      '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h8000_0000, 1'b0, 1'b1, 8'd0,   8'd0,   8'd0},
      // Empty range: span of 1.0 starting at the low end.
      '{32'h0001_0000, 32'h0001_0000, 1'b0, 32'h0001_0000, 1'b0, 1'b1, 8'd0,   8'd0,   8'd0},
      '{32'h0001_0000, 32'h0001_0000, 1'b0, 32'h0001_8000, 1'b0, 1'b1, 8'd127, 8'd127, 8'd127},
      '{32'h0001_0000, 32'h0001_0000, 1'b0, 32'h0002_0000, 1'b1, 1'b1, 8'd255, 8'd255, 8'd255},
      // Widest possible range, diverging palette.
      '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 1'b0, 1'b1, 8'd4,   8'd47,  8'd97},
      '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b1, 8'd165, 8'd0,   8'd37},
      '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, 1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
      '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, 8'd0,   8'd0,   8'd0}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part; the range is reloaded whenever a row asks for a new one.
    for (n = 0; n < DIR_ROWS; n++) begin
      if (dir_rows[n].low != cur_low || dir_rows[n].high != cur_high ||
          dir_rows[n].sel != cur_map) begin
        load_range(dir_rows[n].low, dir_rows[n].high, dir_rows[n].sel);
      end
      if (dir_rows[n].known) begin
        exp_col.red = dir_rows[n].red;
        exp_col.green = dir_rows[n].green;
        exp_col.blue = dir_rows[n].blue;
        exp_col.last = dir_rows[n].lst;
      end else begin
        exp_col = predict_color(dir_rows[n].smp, dir_rows[n].lst);
      end
      push_sample(dir_rows[n].smp, dir_rows[n].lst, exp_col);
    end

    // Random phases: each range shape once per colormap.
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      sel = (phase < RAND_PHASES / 2);
      lo_v = longint'($urandom_range(32'h7FFF_FFFF)) - 64'sd1073741824;
      case (phase % 5)
        0: begin
          lo_v = 0;
          hi_v = 65536;
        end
        1: begin
          hi_v = lo_v + $urandom_range(1, 1 << $urandom_range(1, 24));
        end
        2: begin
          lo_v = -64'sd2147483648;
          hi_v = 64'sd2147483647;
        end
        3: begin
          hi_v = lo_v - $urandom_range(0, 1000);
        end
        default: begin
          lo_v = longint'(signed'($urandom()));
          hi_v = longint'(signed'($urandom()));
        end
      endcase
      lo_w = lo_v[31:0];
      hi_w = hi_v[31:0];
      load_range(lo_w, hi_w, sel);
      lo_v = longint'(signed'(lo_w));
      eff = longint'(signed'(hi_w)) - lo_v;
      if (eff <= 0) begin
        eff = EMPTY_SPAN;
      end

      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 47;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 47;
        end
        default: begin
          send_idle_pct = 14;
          recv_stall_pct = 14;
        end
      endcase
      // Long result-side hold-off while samples keep coming, to back up the pipeline.
      if (phase == 4) begin
        hold_arm <= 1'b1;
      end

      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Let the pipeline run empty once in the middle of a phase.
        if (phase == 5 && n == PHASE_ITEMS / 2) begin
          wait_drained();
        end
        pick = $urandom_range(99);
        if (pick < 60) begin
          val = lo_v + (longint'($urandom()) % eff);
        end else if (pick < 70) begin
          val = lo_v + eff;
        end else if (pick < 75) begin
          val = lo_v;
        end else if (pick < 80) begin
          val = lo_v - 1;
        end else begin
          val = longint'($urandom());
        end
        smp = val[31:0];
        lst_bit = ($urandom_range(7) == 0);
        push_sample(smp, lst_bit, predict_color(smp, lst_bit));
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
